[rtl/zsbd_pkg.sv]
package zsbd_pkg;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
    localparam logic [STATUS_W-1:0] ST_END        = 4'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_METHOD = 4'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_WINDOW = 4'd3;
    localparam logic [STATUS_W-1:0] ST_HDR_CHECK  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DICT       = 4'd5;
    localparam logic [STATUS_W-1:0] ST_UNSUPP     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_NLEN       = 4'd7;
    localparam logic [STATUS_W-1:0] ST_ADLER      = 4'd8;
    localparam logic [STATUS_W-1:0] ST_AFTER_STOP = 4'd9;

    // Header field constants
    localparam logic [3:0] CM_DEFLATE = 4'd8;
    localparam logic [3:0] CINFO_MAX  = 4'd7;

    // Block types
    localparam logic [1:0] BTYPE_STORED = 2'd0;

    // Adler-32 modulus, one bit wider than the 16-bit running sums
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_BLOCK   = 3'd1,
        PH_STORED  = 3'd2,
        PH_TRAILER = 3'd3,
        PH_END     = 3'd4
    } phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                out_valid;
        logic [BYTE_W-1:0]   out_byte;
    } result_t;

endpackage

[rtl/zsbd_in_if.sv]
interface zsbd_in_if
    import zsbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

[rtl/zsbd_out_if.sv]
interface zsbd_out_if
    import zsbd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                out_valid;
    logic [BYTE_W-1:0]   out_byte;

    modport source (output valid, output status, output out_valid, output out_byte,
                    input ready);
    modport sink (input valid, input status, input out_valid, input out_byte,
                  output ready);
endinterface

[rtl/zlib_stored_block_deframer.sv]
// zlib stream deframer for stored blocks. Takes one stream byte per beat and
// returns exactly one result beat for it (status, payload flag, payload byte),
// in order. A byte can be accepted in every clock cycle: the parse state and
// the running Adler-32 are updated in the same cycle the byte is taken, and the
// result is registered (in the skid one if the output is stalled). The rate is
// set by the Adler-32 update (two adds, each with a modulo correction). A skid
// register behind the output register holds one extra beat, so input ready
// only drops while the output side is stalled with both registers full. Errors
// are sticky until reset; after the trailer matches, every byte gets status 9.
module zlib_stored_block_deframer
    import zsbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    zsbd_in_if.sink    in_ch,
    zsbd_out_if.source out_ch
);

    // Parse state
    phase_t              phase_reg, phase_next;
    logic [1:0]          field_count_reg, field_count_next;
    logic [7:0]          first_hdr_reg, first_hdr_next;
    logic                last_block_reg, last_block_next;
    logic                length_known_reg, length_known_next;
    logic [15:0]         block_len_reg, block_len_next;
    logic [7:0]          nlen_low_reg, nlen_low_next;
    logic [15:0]         payload_count_reg, payload_count_next;
    logic [15:0]         adler_low_reg, adler_low_next;
    logic [15:0]         adler_high_reg, adler_high_next;
    logic [31:0]         trailer_reg, trailer_next;
    logic [STATUS_W-1:0] error_reg, error_next;

    // Output register and skid register
    result_t res_reg, skid_reg, res_next;
    logic    res_valid_reg, skid_full_reg;

    logic        acc, take;
    logic [7:0]  b;
    logic [15:0] hdr_word;
    logic [6:0]  mod_sum;
    logic [5:0]  mod_fold;
    logic [16:0] low_sum, high_sum, low_fixed, high_fixed;
    logic [15:0] count_inc;
    logic [15:0] nlen_word;

    assign acc  = in_ch.valid && in_ch.ready;
    assign take = out_ch.valid && out_ch.ready;
    assign b    = in_ch.in_byte;

    // Header check by 31: 32 is 1 mod 31, so 5-bit digits add up
    assign hdr_word = {first_hdr_reg, b};
    assign mod_sum  = 7'(hdr_word[4:0]) + 7'(hdr_word[9:5]) + 7'(hdr_word[14:10])
                      + 7'(hdr_word[15]);
    assign mod_fold = 6'(mod_sum[4:0]) + 6'(mod_sum[6:5]);

    // Adler-32 update, each sum stays below twice the modulus
    assign low_sum    = {1'b0, adler_low_reg} + 17'(b);
    assign low_fixed  = (low_sum >= ADLER_MOD) ? (low_sum - ADLER_MOD) : low_sum;
    assign high_sum   = {1'b0, adler_high_reg} + low_fixed;
    assign high_fixed = (high_sum >= ADLER_MOD) ? (high_sum - ADLER_MOD) : high_sum;

    assign count_inc = payload_count_reg + 16'd1;
    assign nlen_word = {b, nlen_low_reg};

    // Next state and result for the byte at the input
    always_comb
    begin
        phase_next         = phase_reg;
        field_count_next   = field_count_reg;
        first_hdr_next     = first_hdr_reg;
        last_block_next    = last_block_reg;
        length_known_next  = length_known_reg;
        block_len_next     = block_len_reg;
        nlen_low_next      = nlen_low_reg;
        payload_count_next = payload_count_reg;
        adler_low_next     = adler_low_reg;
        adler_high_next    = adler_high_reg;
        trailer_next       = trailer_reg;
        error_next         = error_reg;
        res_next.status    = ST_OK;
        res_next.out_valid = 1'b0;
        res_next.out_byte  = '0;

        if (error_reg != ST_OK)
        begin
            res_next.status = error_reg;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (field_count_reg == 2'd0)
                    begin
                        first_hdr_next = b;
                        if (b[3:0] != CM_DEFLATE)
                            error_next = ST_BAD_METHOD;
                        else if (b[7:4] > CINFO_MAX)
                            error_next = ST_BAD_WINDOW;
                        else
                            field_count_next = 2'd1;
                    end
                    else
                    begin
                        if (mod_fold != 6'd0 && mod_fold != 6'd31)
                            error_next = ST_HDR_CHECK;
                        else if (b[5])
                            error_next = ST_DICT;
                        else
                        begin
                            field_count_next = 2'd0;
                            phase_next       = PH_BLOCK;
                        end
                    end
                    res_next.status = error_next;
                end

                PH_BLOCK:
                begin
                    last_block_next = b[0];
                    if (b[2:1] != BTYPE_STORED)
                        error_next = ST_UNSUPP;
                    else
                    begin
                        phase_next         = PH_STORED;
                        length_known_next  = 1'b0;
                        field_count_next   = 2'd0;
                        payload_count_next = '0;
                    end
                    res_next.status = error_next;
                end

                PH_STORED:
                begin
                    if (!length_known_reg)
                    begin
                        case (field_count_reg)
                            2'd0:
                            begin
                                block_len_next   = {8'd0, b};
                                field_count_next = 2'd1;
                            end
                            2'd1:
                            begin
                                block_len_next   = {b, block_len_reg[7:0]};
                                field_count_next = 2'd2;
                            end
                            2'd2:
                            begin
                                nlen_low_next    = b;
                                field_count_next = 2'd3;
                            end
                            default:
                            begin
                                if (block_len_reg != ~nlen_word)
                                    error_next = ST_NLEN;
                                else
                                begin
                                    field_count_next   = 2'd0;
                                    length_known_next  = 1'b1;
                                    payload_count_next = '0;
                                    // empty block finishes right here
                                    if (block_len_reg == 16'd0)
                                    begin
                                        length_known_next = 1'b0;
                                        block_len_next    = '0;
                                        nlen_low_next     = '0;
                                        if (last_block_reg)
                                        begin
                                            phase_next   = PH_TRAILER;
                                            trailer_next = '0;
                                        end
                                        else
                                            phase_next = PH_BLOCK;
                                    end
                                end
                            end
                        endcase
                        res_next.status = error_next;
                    end
                    else
                    begin
                        res_next.out_valid = 1'b1;
                        res_next.out_byte  = b;
                        adler_low_next     = low_fixed[15:0];
                        adler_high_next    = high_fixed[15:0];
                        payload_count_next = count_inc;
                        if (count_inc >= block_len_reg)
                        begin
                            length_known_next  = 1'b0;
                            field_count_next   = 2'd0;
                            payload_count_next = '0;
                            block_len_next     = '0;
                            nlen_low_next      = '0;
                            if (last_block_reg)
                            begin
                                phase_next   = PH_TRAILER;
                                trailer_next = '0;
                            end
                            else
                                phase_next = PH_BLOCK;
                        end
                    end
                end

                PH_TRAILER:
                begin
                    trailer_next = {trailer_reg[23:0], b};
                    if (field_count_reg != 2'd3)
                        field_count_next = field_count_reg + 2'd1;
                    else if (trailer_next != {adler_high_reg, adler_low_reg})
                        error_next = ST_ADLER;
                    else
                    begin
                        phase_next      = PH_END;
                        res_next.status = ST_END;
                    end
                    if (error_next != ST_OK)
                        res_next.status = error_next;
                end

                default:
                begin
                    res_next.status = ST_AFTER_STOP;
                end
            endcase
        end
    end

    // Parse state registers, updated on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            field_count_reg   <= '0;
            first_hdr_reg     <= '0;
            last_block_reg    <= 1'b0;
            length_known_reg  <= 1'b0;
            block_len_reg     <= '0;
            nlen_low_reg      <= '0;
            payload_count_reg <= '0;
            adler_low_reg     <= 16'd1;
            adler_high_reg    <= '0;
            trailer_reg       <= '0;
            error_reg         <= ST_OK;
        end
        else if (acc)
        begin
            phase_reg         <= phase_next;
            field_count_reg   <= field_count_next;
            first_hdr_reg     <= first_hdr_next;
            last_block_reg    <= last_block_next;
            length_known_reg  <= length_known_next;
            block_len_reg     <= block_len_next;
            nlen_low_reg      <= nlen_low_next;
            payload_count_reg <= payload_count_next;
            adler_low_reg     <= adler_low_next;
            adler_high_reg    <= adler_high_next;
            trailer_reg       <= trailer_next;
            error_reg         <= error_next;
        end
    end

    // Output and skid occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (take)
                skid_full_reg <= 1'b0;
        end
        else if (acc)
        begin
            if (res_valid_reg && !take)
                skid_full_reg <= 1'b1;
            res_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (take)
                res_reg <= skid_reg;
        end
        else if (acc)
        begin
            if (res_valid_reg && !take)
                skid_reg <= res_next;
            else
                res_reg <= res_next;
        end
    end

    assign in_ch.ready      = !skid_full_reg;
    assign out_ch.valid     = res_valid_reg;
    assign out_ch.status    = res_reg.status;
    assign out_ch.out_valid = res_reg.out_valid;
    assign out_ch.out_byte  = res_reg.out_byte;

    // A held skid beat always sits behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> res_valid_reg)
        else $error("skid holds a beat while output register is empty");

    // Errors are sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        (error_reg != ST_OK) |=> $stable(error_reg))
        else $error("error code changed after an error");

    // Payload only comes out of a stored block past its length fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc && res_next.out_valid) |-> (phase_reg == PH_STORED && length_known_reg))
        else $error("payload beat outside stored block data");

    // A matched trailer leaves no error behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_END) |-> (error_reg == ST_OK))
        else $error("error recorded after end of stream");

endmodule
